// ----- rtl/core/nkp_pkg.sv -----
// Package for the nearest-K point selector: field widths, function and
// register codes, bounding box limits and the cell control word.
// No dependencies.
`default_nettype none

package nkp_pkg;

   // Field widths
   localparam int COORD_W = 31;
   localparam int ID_W    = 32;
   localparam int DIST_W  = 64;
   localparam int MAG_W   = 32;
   localparam int FUNC_W  = 2;
   localparam int QCNT_W  = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   // Bounding box reset values
   localparam logic signed [COORD_W-1:0] COORD_MAXV = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MINV = {1'b1, {(COORD_W-1){1'b0}}};

   localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_POINT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_Z     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_Z       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_COUNT = 3'd4;

   // Per-cell control from the list controller
   typedef struct packed {
      logic occupied;   // cell lies below the fill count
      logic at_fill;    // cell is the first free place
      logic at_tail;    // cell is the last occupied place
      logic insert;     // a new entry goes into the list this cycle
      logic grow;       // the list grows by one on this insert
      logic rotate;     // list turns by one place towards the head
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/core/nkp_req_if.sv -----
// Request channel interface: valid/ready handshake with one point or
// command word. Depends on nkp_pkg.
`default_nettype none

interface nkp_req_if
   import nkp_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic signed [COORD_W-1:0] pt_x;
   logic signed [COORD_W-1:0] pt_y;
   logic signed [COORD_W-1:0] pt_z;

   modport source (output valid, output func, output pt_x, output pt_y,
                   output pt_z, input ready);
   modport sink   (input valid, input func, input pt_x, input pt_y,
                   input pt_z, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/nkp_rsp_if.sv -----
// Response channel interface: valid/ready handshake with one report word.
// Depends on nkp_pkg.
`default_nettype none

interface nkp_rsp_if
   import nkp_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic                      entry_valid;
   logic [ID_W-1:0]           entry_id;
   logic [DIST_W-1:0]         entry_distance;
   logic signed [COORD_W-1:0] min_x;
   logic signed [COORD_W-1:0] min_y;
   logic signed [COORD_W-1:0] min_z;
   logic signed [COORD_W-1:0] max_x;
   logic signed [COORD_W-1:0] max_y;
   logic signed [COORD_W-1:0] max_z;
   logic [ID_W-1:0]           points_seen;
   logic                      last;

   modport source (output valid, output entry_valid, output entry_id,
                   output entry_distance, output min_x, output min_y,
                   output min_z, output max_x, output max_y, output max_z,
                   output points_seen, output last, input ready);
   modport sink   (input valid, input entry_valid, input entry_id,
                   input entry_distance, input min_x, input min_y,
                   input min_z, input max_x, input max_y, input max_z,
                   input points_seen, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/nkp_dist.sv -----
// Squared distance pipeline: difference magnitudes, squares, sum.
// Three register stages. Depends on nkp_pkg.
`default_nettype none

module nkp_dist
   import nkp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic signed [COORD_W-1:0] pt_x,
   input  wire logic signed [COORD_W-1:0] pt_y,
   input  wire logic signed [COORD_W-1:0] pt_z,
   input  wire logic signed [COORD_W-1:0] query_x,
   input  wire logic signed [COORD_W-1:0] query_y,
   input  wire logic signed [COORD_W-1:0] query_z,
   input  wire logic                      use_z,
   output logic                           done,
   output logic [DIST_W-1:0]              distance
);

   logic [2:0]              stage_valid_ff;
   logic [MAG_W-1:0]        mag_x_ff, mag_y_ff, mag_z_ff;
   logic [MAG_W-1:0]        mag_x_in, mag_y_in, mag_z_in;
   logic [DIST_W-1:0]       sq_x_ff, sq_y_ff, sq_z_ff;
   logic [DIST_W-1:0]       sum_ff;
   logic signed [MAG_W-1:0] dx, dy, dz;

   // Exact differences, one bit wider than the coordinates, then magnitudes.
   always_comb begin
      dx = MAG_W'(pt_x) - MAG_W'(query_x);
      dy = MAG_W'(pt_y) - MAG_W'(query_y);
      dz = MAG_W'(pt_z) - MAG_W'(query_z);
      mag_x_in = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      mag_y_in = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
      if (use_z) begin
         mag_z_in = dz[MAG_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
      end else begin
         mag_z_in = '0;
      end
   end

   // Stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= {stage_valid_ff[1:0], start};
      end
   end

   // Data stages: magnitudes, squares, sum. The sum stays below 2^64.
   always_ff @(posedge clock) begin
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      mag_z_ff <= mag_z_in;
      sq_x_ff  <= DIST_W'(mag_x_ff) * DIST_W'(mag_x_ff);
      sq_y_ff  <= DIST_W'(mag_y_ff) * DIST_W'(mag_y_ff);
      sq_z_ff  <= DIST_W'(mag_z_ff) * DIST_W'(mag_z_ff);
      sum_ff   <= sq_x_ff + sq_y_ff + sq_z_ff;
   end

   assign done     = stage_valid_ff[2];
   assign distance = sum_ff;

endmodule

`default_nettype wire

// ----- rtl/core/nkp_cell.sv -----
// One place of the sorted nearest list: holds a distance and an id, and
// takes a new entry, its left neighbour, its right neighbour or the head entry. Depends on nkp_pkg.
`default_nettype none

module nkp_cell
   import nkp_pkg::*;
(
   input  wire logic              clock,
   input  wire cell_ctl_type      ctl,
   input  wire logic [DIST_W-1:0] ins_dist,
   input  wire logic [ID_W-1:0]   ins_id,
   input  wire logic              left_gt,
   input  wire logic [DIST_W-1:0] left_dist,
   input  wire logic [ID_W-1:0]   left_id,
   input  wire logic [DIST_W-1:0] right_dist,
   input  wire logic [ID_W-1:0]   right_id,
   input  wire logic [DIST_W-1:0] head_dist,
   input  wire logic [ID_W-1:0]   head_id,
   output logic                   gt,
   output logic [DIST_W-1:0]      distance,
   output logic [ID_W-1:0]        id
);

   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [ID_W-1:0]   id_ff, id_in;

   // A strictly larger held distance makes the new entry go in front; ties
   // keep the new entry behind.
   assign gt = ctl.occupied && (dist_ff > ins_dist);

   // Next contents: rotation for reports, shift or take for inserts.
   always_comb begin
      dist_in = dist_ff;
      id_in   = id_ff;
      if (ctl.rotate) begin
         if (ctl.occupied) begin
            if (ctl.at_tail) begin
               dist_in = head_dist;
               id_in   = head_id;
            end else begin
               dist_in = right_dist;
               id_in   = right_id;
            end
         end
      end else if (ctl.insert) begin
         if (left_gt) begin
            dist_in = left_dist;
            id_in   = left_id;
         end else if (gt || (ctl.at_fill && ctl.grow)) begin
            dist_in = ins_dist;
            id_in   = ins_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      id_ff   <= id_in;
   end

   assign distance = dist_ff;
   assign id       = id_ff;

endmodule

`default_nettype wire

// ----- rtl/core/nearest_k_points_with_bounds_unit.sv -----
// Nearest-K point selector with running bounding box. For a point word, the
// acceptance cycle updates bounds and count and forms the coordinate
// differences, the distance pipeline with its three 32x32 multipliers then
// squares and sums them in its square and sum stages, and its done signal
// inserts the result into a chain of MAX_NEAR list cells that compare and
// shift in the same cycle. A clear or an ignored function code finishes in
// its acceptance cycle. A report takes its acceptance cycle and then sends
// max(1, fill) words, one a cycle while the response side takes them, by
// turning the cell chain towards its head; the list is back in place when the report ends.
// A new request is taken while the last response word still waits.
// Depends on nkp_pkg, nkp_req_if, nkp_rsp_if, nkp_dist and nkp_cell.
`default_nettype none

module nearest_k_points_with_bounds_unit
   import nkp_pkg::*;
#(
   parameter int MAX_NEAR = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   nkp_req_if.sink                    req_chan,
   nkp_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int FW = $clog2(MAX_NEAR + 1);
   localparam int KW = (FW > QCNT_W) ? FW : QCNT_W;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DIST   = 4'b0010,
      S_REPORT = 4'b0100,
      S_SPARE  = 4'b1000
   } state_type;

   // Configuration registers
   logic signed [COORD_W-1:0] query_x_ff, query_y_ff, query_z_ff;
   logic                      use_z_ff;
   logic [QCNT_W-1:0]         query_count_ff;

   // Run state
   state_type                 state_ff, state_in;
   logic [FW-1:0]             fill_ff, fill_in;
   logic [FW-1:0]             rep_cnt_ff, rep_cnt_in;
   logic [ID_W-1:0]           counter_ff;
   logic [ID_W-1:0]           point_id_ff;
   logic signed [COORD_W-1:0] box_min_x_ff, box_min_y_ff, box_min_z_ff;
   logic signed [COORD_W-1:0] box_max_x_ff, box_max_y_ff, box_max_z_ff;

   // Response register
   logic                      rsp_valid_ff;
   logic                      rsp_entry_valid_ff;
   logic [ID_W-1:0]           rsp_entry_id_ff;
   logic [DIST_W-1:0]         rsp_entry_distance_ff;
   logic signed [COORD_W-1:0] rsp_min_x_ff, rsp_min_y_ff, rsp_min_z_ff;
   logic signed [COORD_W-1:0] rsp_max_x_ff, rsp_max_y_ff, rsp_max_z_ff;
   logic [ID_W-1:0]           rsp_points_ff;
   logic                      rsp_last_ff;

   logic                      req_fire;
   logic                      dist_start;
   logic                      dist_done;
   logic [DIST_W-1:0]         dist_value;
   logic [KW-1:0]             k_raw, k_eff;
   logic                      grow;
   logic                      any_gt;
   logic                      do_insert;
   logic                      out_free;
   logic                      rsp_load;
   logic                      rep_last;
   logic                      rotate;

   logic [MAX_NEAR-1:0]       cell_gt;
   logic [DIST_W-1:0]         cell_dist [MAX_NEAR];
   logic [ID_W-1:0]           cell_id   [MAX_NEAR];

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign dist_start     = req_fire && (req_chan.func == FUNC_POINT);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         query_x_ff     <= '0;
         query_y_ff     <= '0;
         query_z_ff     <= '0;
         use_z_ff       <= 1'b0;
         query_count_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_QUERY_X:     query_x_ff     <= csr_write_data[COORD_W-1:0];
            CSR_QUERY_Y:     query_y_ff     <= csr_write_data[COORD_W-1:0];
            CSR_QUERY_Z:     query_z_ff     <= csr_write_data[COORD_W-1:0];
            CSR_USE_Z:       use_z_ff       <= csr_write_data[0];
            CSR_QUERY_COUNT: query_count_ff <= csr_write_data[QCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Distance pipeline
   nkp_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .start    (dist_start),
      .pt_x     (req_chan.pt_x),
      .pt_y     (req_chan.pt_y),
      .pt_z     (req_chan.pt_z),
      .query_x  (query_x_ff),
      .query_y  (query_y_ff),
      .query_z  (query_z_ff),
      .use_z    (use_z_ff),
      .done     (dist_done),
      .distance (dist_value)
   );

   // Insert decision: grow while below K, otherwise replace only on a
   // strictly smaller distance than the tail.
   always_comb begin
      k_raw     = KW'(query_count_ff);
      k_eff     = (k_raw > KW'(MAX_NEAR)) ? KW'(MAX_NEAR) : k_raw;
      grow      = KW'(fill_ff) < k_eff;
      any_gt    = |cell_gt;
      do_insert = dist_done && (k_eff != '0) && (grow || any_gt);
   end

   // Report sequencing
   always_comb begin
      out_free = !rsp_valid_ff || rsp_chan.ready;
      rsp_load = (state_ff == S_REPORT) && out_free;
      rep_last = (fill_ff == '0) || (rep_cnt_ff == fill_ff - FW'(1));
      rotate   = rsp_load && (fill_ff != '0);
   end

   // List cells
   for (genvar i = 0; i < MAX_NEAR; i++) begin : g_cell
      cell_ctl_type      ctl;
      logic              left_gt;
      logic [DIST_W-1:0] left_dist, right_dist;
      logic [ID_W-1:0]   left_id, right_id;

      always_comb begin
         ctl.occupied = FW'(i) < fill_ff;
         ctl.at_fill  = FW'(i) == fill_ff;
         ctl.at_tail  = FW'(i + 1) == fill_ff;
         ctl.insert   = do_insert;
         ctl.grow     = grow;
         ctl.rotate   = rotate;
      end

      if (i == 0) begin : g_head
         assign left_gt   = 1'b0;
         assign left_dist = dist_value;
         assign left_id   = point_id_ff;
      end else begin : g_body
         assign left_gt   = cell_gt[i-1];
         assign left_dist = cell_dist[i-1];
         assign left_id   = cell_id[i-1];
      end

      if (i == MAX_NEAR - 1) begin : g_end
         assign right_dist = cell_dist[0];
         assign right_id   = cell_id[0];
      end else begin : g_mid
         assign right_dist = cell_dist[i+1];
         assign right_id   = cell_id[i+1];
      end

      nkp_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .ins_dist   (dist_value),
         .ins_id     (point_id_ff),
         .left_gt    (left_gt),
         .left_dist  (left_dist),
         .left_id    (left_id),
         .right_dist (right_dist),
         .right_id   (right_id),
         .head_dist  (cell_dist[0]),
         .head_id    (cell_id[0]),
         .gt         (cell_gt[i]),
         .distance   (cell_dist[i]),
         .id         (cell_id[i])
      );
   end

   // Controller next state, fill count and report counter
   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      rep_cnt_in = rep_cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_chan.func)
                  FUNC_POINT:  state_in = S_DIST;
                  FUNC_REPORT: state_in = S_REPORT;
                  FUNC_CLEAR:  fill_in  = '0;
                  default: ;
               endcase
            end
         end
         S_DIST: begin
            if (dist_done) begin
               state_in = S_IDLE;
               if (do_insert && grow) begin
                  fill_in = fill_ff + FW'(1);
               end
            end
         end
         S_REPORT: begin
            if (rsp_load) begin
               if (rep_last) begin
                  rep_cnt_in = '0;
                  state_in   = S_IDLE;
               end else begin
                  rep_cnt_in = rep_cnt_ff + FW'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fill_ff    <= '0;
         rep_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         rep_cnt_ff <= rep_cnt_in;
      end
   end

   // Point count and bounding box, updated as a point word is accepted and reset by a clear
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         box_min_x_ff <= COORD_MAXV;
         box_min_y_ff <= COORD_MAXV;
         box_min_z_ff <= COORD_MAXV;
         box_max_x_ff <= COORD_MINV;
         box_max_y_ff <= COORD_MINV;
         box_max_z_ff <= COORD_MINV;
      end else if (req_fire && (req_chan.func == FUNC_CLEAR)) begin
         counter_ff   <= '0;
         box_min_x_ff <= COORD_MAXV;
         box_min_y_ff <= COORD_MAXV;
         box_min_z_ff <= COORD_MAXV;
         box_max_x_ff <= COORD_MINV;
         box_max_y_ff <= COORD_MINV;
         box_max_z_ff <= COORD_MINV;
      end else if (dist_start) begin
         if (counter_ff != ID_MAX) begin
            counter_ff <= counter_ff + ID_W'(1);
         end
         if (req_chan.pt_x < box_min_x_ff) box_min_x_ff <= req_chan.pt_x;
         if (req_chan.pt_y < box_min_y_ff) box_min_y_ff <= req_chan.pt_y;
         if (req_chan.pt_z < box_min_z_ff) box_min_z_ff <= req_chan.pt_z;
         if (req_chan.pt_x > box_max_x_ff) box_max_x_ff <= req_chan.pt_x;
         if (req_chan.pt_y > box_max_y_ff) box_max_y_ff <= req_chan.pt_y;
         if (req_chan.pt_z > box_max_z_ff) box_max_z_ff <= req_chan.pt_z;
      end
   end

   // Sequence number of the point in flight
   always_ff @(posedge clock) begin
      if (dist_start) begin
         point_id_ff <= counter_ff;
      end
   end

   // Response register: holds a word until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_entry_valid_ff    <= (fill_ff != '0);
         rsp_entry_id_ff       <= (fill_ff != '0) ? cell_id[0] : '0;
         rsp_entry_distance_ff <= (fill_ff != '0) ? cell_dist[0] : '0;
         rsp_min_x_ff          <= box_min_x_ff;
         rsp_min_y_ff          <= box_min_y_ff;
         rsp_min_z_ff          <= box_min_z_ff;
         rsp_max_x_ff          <= box_max_x_ff;
         rsp_max_y_ff          <= box_max_y_ff;
         rsp_max_z_ff          <= box_max_z_ff;
         rsp_points_ff         <= counter_ff;
         rsp_last_ff           <= rep_last;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.entry_valid    = rsp_entry_valid_ff;
   assign rsp_chan.entry_id       = rsp_entry_id_ff;
   assign rsp_chan.entry_distance = rsp_entry_distance_ff;
   assign rsp_chan.min_x          = rsp_min_x_ff;
   assign rsp_chan.min_y          = rsp_min_y_ff;
   assign rsp_chan.min_z          = rsp_min_z_ff;
   assign rsp_chan.max_x          = rsp_max_x_ff;
   assign rsp_chan.max_y          = rsp_max_y_ff;
   assign rsp_chan.max_z          = rsp_max_z_ff;
   assign rsp_chan.points_seen    = rsp_points_ff;
   assign rsp_chan.last           = rsp_last_ff;

endmodule

`default_nettype wire

// ----- tb/sv/nearest_k_points_with_bounds_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench for nearest_k_points_with_bounds_unit: directed and random point streams,
// with every report word checked against a behavioural nearest-list model.
// Depends on nkp_pkg, nkp_req_if, nkp_rsp_if and the unit itself.

module nearest_k_points_with_bounds_unit_tb;
   import nkp_pkg::*;

   localparam int MAX_NEAR      = 16;
   localparam int AXES          = 3;
   localparam int IDLE_PCT      = 17;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_ITEMS  = 115;
   localparam int REPORT_LIMIT  = 10;
   // Far above the slowest legal run: full reports, long stalls and settling pauses.
   localparam int CYCLE_LIMIT   = 200000;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // Point styles for random coordinates
   localparam int STYLE_NEAR    = 0;
   localparam int STYLE_ANY     = 1;
   localparam int STYLE_EXTREME = 2;

   typedef struct packed {
      logic                             entry_valid;
      logic [ID_W-1:0]                  entry_id;
      logic [DIST_W-1:0]                entry_distance;
      logic [AXES-1:0][COORD_W-1:0]     box_lo;
      logic [AXES-1:0][COORD_W-1:0]     box_hi;
      logic [ID_W-1:0]                  points_seen;
      logic                             last;
   } report_word_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   nkp_req_if req_chan ();
   nkp_rsp_if rsp_chan ();

   nearest_k_points_with_bounds_unit #(
      .MAX_NEAR(MAX_NEAR)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   // Model state: registers, the sorted nearest list and the run totals.
   logic signed [COORD_W-1:0] query_at [AXES];
   logic                      use_depth;
   logic [QCNT_W-1:0]         keep_count;
   logic [DIST_W-1:0]         near_dist [MAX_NEAR];
   logic [ID_W-1:0]           near_tag [MAX_NEAR];
   int                        near_used;
   logic [ID_W-1:0]           seen_count;
   logic signed [COORD_W-1:0] run_lo [AXES];
   logic signed [COORD_W-1:0] run_hi [AXES];

   report_word_type pending_words [$];
   int              mismatch_count;
   int              cycle_count = 0;
   int              items_sent;
   bit              steady;

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // ---------------------------------------------------------------------------------------
   // Model of the unit
   // ---------------------------------------------------------------------------------------

   function automatic logic [DIST_W-1:0] axis_square(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] gap;
      logic [COORD_W:0]        mag;
      gap = a - b;
      mag = (gap < 0) ? -gap : gap;
      return DIST_W'(mag) * DIST_W'(mag);
   endfunction

   function automatic void restart_run();
      near_used  = 0;
      seen_count = '0;
      for (int a = 0; a < AXES; a++) begin
         run_lo[a] = COORD_MAXV;
         run_hi[a] = COORD_MINV;
      end
   endfunction

   // Widen the box, count the point and place it in the nearest list.
   function automatic void take_point(input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y,
                                      input logic signed [COORD_W-1:0] z);
      logic signed [COORD_W-1:0] pt [AXES];
      logic [DIST_W-1:0]         sq_sum;
      int                        k;
      int                        pos;
      int                        stop;
      bit                        grow;
      pt[0] = x;
      pt[1] = y;
      pt[2] = z;
      k = (keep_count > MAX_NEAR) ? MAX_NEAR : int'(keep_count);
      for (int a = 0; a < AXES; a++) begin
         if (pt[a] < run_lo[a]) run_lo[a] = pt[a];
         if (pt[a] > run_hi[a]) run_hi[a] = pt[a];
      end
      if (k != 0) begin
         sq_sum = axis_square(x, query_at[0]) + axis_square(y, query_at[1]);
         if (use_depth) sq_sum += axis_square(z, query_at[2]);
         grow = (near_used < k);
         // A full list only takes a strictly smaller distance than its tail.
         if (grow || (near_used > 0 && sq_sum < near_dist[near_used - 1])) begin
            pos = 0;
            while (pos < near_used && near_dist[pos] <= sq_sum) pos++;
            stop = grow ? near_used : near_used - 1;
            for (int i = stop; i > pos; i--) begin
               near_dist[i] = near_dist[i - 1];
               near_tag[i]  = near_tag[i - 1];
            end
            near_dist[pos] = sq_sum;
            near_tag[pos]  = seen_count;
            if (grow) near_used++;
         end
      end
      if (seen_count != ID_MAX) seen_count++;
   endfunction

   function automatic report_word_type make_word(input logic ok, input logic [ID_W-1:0] tag,
                                                 input logic [DIST_W-1:0] sq,
                                                 input logic fin);
      report_word_type w;
      w.entry_valid    = ok;
      w.entry_id       = tag;
      w.entry_distance = sq;
      for (int a = 0; a < AXES; a++) begin
         w.box_lo[a] = run_lo[a];
         w.box_hi[a] = run_hi[a];
      end
      w.points_seen = seen_count;
      w.last        = fin;
      return w;
   endfunction

   // Append one expected word at the end of the queue.
   function automatic void add_expected(input report_word_type w);
      pending_words.insert(pending_words.size(), w);
   endfunction

   // A report lists the kept points in order; an empty list gives one blank word.
   function automatic void queue_report();
      if (near_used == 0)
         add_expected(make_word(1'b0, '0, '0, 1'b1));
      else
         for (int i = 0; i < near_used; i++)
            add_expected(make_word(1'b1, near_tag[i], near_dist[i], i == near_used - 1));
   endfunction

   function automatic void apply_request(input logic [FUNC_W-1:0] func,
                                         input logic signed [COORD_W-1:0] x,
                                         input logic signed [COORD_W-1:0] y,
                                         input logic signed [COORD_W-1:0] z);
      case (func)
         FUNC_POINT:  take_point(x, y, z);
         FUNC_REPORT: queue_report();
         FUNC_CLEAR:  restart_run();
         default: ;
      endcase
   endfunction

   function automatic void latch_register(input logic [CSR_IDX_W-1:0]  idx,
                                          input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_QUERY_X:     query_at[0] = data;
         CSR_QUERY_Y:     query_at[1] = data;
         CSR_QUERY_Z:     query_at[2] = data;
         CSR_USE_Z:       use_depth   = data[0];
         CSR_QUERY_COUNT: keep_count  = data[QCNT_W-1:0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------

   function automatic logic signed [COORD_W-1:0] any_coord();
      return COORD_W'($urandom);
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_coord(
      input logic signed [COORD_W-1:0] centre, input int style);
      longint v;
      case (style)
         STYLE_NEAR: begin
            // Small offsets around the query give many equal distances.
            v = longint'(centre) + longint'($urandom_range(8)) - 64'sd4;
            if (v > COORD_MAXV) v = COORD_MAXV;
            if (v < COORD_MINV) v = COORD_MINV;
            return COORD_W'(v);
         end
         STYLE_EXTREME: return $urandom_range(1) ? COORD_MAXV : COORD_MINV;
         default:       return any_coord();
      endcase
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_query();
      case ($urandom_range(5))
         0:       return COORD_MAXV;
         1:       return COORD_MINV;
         2:       return COORD_W'($urandom_range(200)) - 100;
         default: return any_coord();
      endcase
   endfunction

   // Send one request word; valid is left high for a following word.
   task automatic send_word(input logic [FUNC_W-1:0] func,
                            input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic signed [COORD_W-1:0] z);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func  <= func;
      req_chan.pt_x  <= x;
      req_chan.pt_y  <= y;
      req_chan.pt_z  <= z;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      apply_request(func, x, y, z);
      if (func != FUNC_UNUSED) items_sent++;
      @(negedge clock);
   endtask

   // Hold off requests until every report word is back and the point pipeline is empty.
   task automatic wait_quiet();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0]  idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      latch_register(idx, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Bits above the flag and the count are filled with noise; the unit ignores them.
   task automatic program_query(input logic signed [COORD_W-1:0] qx,
                                input logic signed [COORD_W-1:0] qy,
                                input logic signed [COORD_W-1:0] qz,
                                input bit depth, input int unsigned k);
      write_register(CSR_QUERY_X, qx);
      write_register(CSR_QUERY_Y, qy);
      write_register(CSR_QUERY_Z, qz);
      write_register(CSR_USE_Z, CSR_DATA_W'({$urandom, depth}));
      write_register(CSR_QUERY_COUNT, CSR_DATA_W'({$urandom, QCNT_W'(k)}));
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Before any point the report is one blank word with the reset bounds; the spare
   // function code and the spare register indexes change nothing.
   task automatic test_empty_run();
      send_word(FUNC_REPORT, '0, '0, '0);
      send_word(FUNC_UNUSED, any_coord(), any_coord(), any_coord());
      wait_quiet();
      for (int idx = CSR_QUERY_COUNT + 1; idx < (1 << CSR_IDX_W); idx++)
         write_register(CSR_IDX_W'(idx), CSR_DATA_W'($urandom));
      send_word(FUNC_REPORT, '0, '0, '0);
   endtask

   // Query and points at opposite corners give the largest 3D distance.
   task automatic test_extreme_distances();
      wait_quiet();
      program_query(COORD_MINV, COORD_MINV, COORD_MINV, 1'b1, 4);
      send_word(FUNC_CLEAR, '0, '0, '0);
      send_word(FUNC_POINT, COORD_MAXV, COORD_MAXV, COORD_MAXV);
      send_word(FUNC_POINT, COORD_MINV, COORD_MINV, COORD_MINV);
      send_word(FUNC_POINT, COORD_MAXV, COORD_MINV, COORD_MAXV);
      send_word(FUNC_POINT, '0, -1, COORD_MAXV);
      send_word(FUNC_REPORT, '0, '0, '0);
   endtask

   // Equal distances queue behind earlier ones; a full list refuses an equal distance
   // and takes a smaller one at its head.
   task automatic test_ties_and_full_list();
      wait_quiet();
      program_query('0, '0, any_coord(), 1'b0, 3);
      send_word(FUNC_CLEAR, '0, '0, '0);
      send_word(FUNC_POINT, 1, 0, any_coord());
      send_word(FUNC_POINT, 0, 1, any_coord());
      send_word(FUNC_POINT, 0, -1, any_coord());
      send_word(FUNC_POINT, -1, 0, any_coord());
      send_word(FUNC_POINT, 0, 0, any_coord());
      send_word(FUNC_REPORT, '0, '0, '0);
   endtask

   // Lowering K below the fill keeps the fill; K of zero only updates box and count.
   task automatic test_count_changes();
      wait_quiet();
      program_query('0, '0, '0, 1'b1, 6);
      send_word(FUNC_CLEAR, '0, '0, '0);
      send_word(FUNC_POINT, 3, 0, 0);
      send_word(FUNC_POINT, 0, 2, 0);
      send_word(FUNC_POINT, 1, 0, 0);
      send_word(FUNC_POINT, 0, 0, 4);
      wait_quiet();
      program_query('0, '0, '0, 1'b1, 2);
      send_word(FUNC_POINT, 5, 0, 0);
      send_word(FUNC_POINT, 0, 1, 1);
      wait_quiet();
      program_query('0, '0, '0, 1'b1, 0);
      send_word(FUNC_POINT, COORD_MINV, COORD_MAXV, 0);
      send_word(FUNC_REPORT, '0, '0, '0);
   endtask

   // Runs of points with random content under changing settings. The first run asks
   // for more than the list can hold, the third runs without any idling.
   task automatic test_random_runs();
      int          phase;
      int          points;
      int          roll;
      int          style;
      int unsigned k;
      phase      = 0;
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         wait_quiet();
         steady = (phase == 2);
         roll   = $urandom_range(9);
         if (phase == 0)  k = $urandom_range(31, MAX_NEAR + 1);
         else if (roll == 0) k = 0;
         else if (roll == 1) k = $urandom_range(31, MAX_NEAR + 1);
         else if (roll < 6)  k = $urandom_range(4, 1);
         else                k = $urandom_range(MAX_NEAR, 1);
         if (phase == 0 || $urandom_range(4) != 0)
            program_query(pick_query(), pick_query(), pick_query(), $urandom_range(1), k);
         if (phase == 0 || $urandom_range(3) != 0)
            send_word(FUNC_CLEAR, any_coord(), any_coord(), any_coord());
         points = (phase == 0) ? MAX_NEAR + 4 : $urandom_range(22, 1);
         for (int p = 0; p < points; p++) begin
            roll = $urandom_range(99);
            if (roll < 6)
               send_word(FUNC_REPORT, any_coord(), any_coord(), any_coord());
            else if (roll < 9)
               send_word(FUNC_UNUSED, any_coord(), any_coord(), any_coord());
            else if (roll < 11)
               send_word(FUNC_CLEAR, any_coord(), any_coord(), any_coord());
            roll  = $urandom_range(99);
            style = (roll < 55) ? STYLE_NEAR : (roll < 85) ? STYLE_ANY : STYLE_EXTREME;
            send_word(FUNC_POINT, pick_coord(query_at[0], style),
                      pick_coord(query_at[1], style), pick_coord(query_at[2], style));
         end
         send_word(FUNC_REPORT, any_coord(), any_coord(), any_coord());
         phase++;
      end
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // Response side: random stalls and the word checker
   // ---------------------------------------------------------------------------------------

   always @(negedge clock)
      rsp_chan.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

   function automatic string word_text(input report_word_type w);
      return $sformatf({"valid=%0b id=%0d dist=%0d lo=(%0d,%0d,%0d) ",
                        "hi=(%0d,%0d,%0d) seen=%0d last=%0b"},
                       w.entry_valid, w.entry_id, w.entry_distance,
                       $signed(w.box_lo[0]), $signed(w.box_lo[1]), $signed(w.box_lo[2]),
                       $signed(w.box_hi[0]), $signed(w.box_hi[1]), $signed(w.box_hi[2]),
                       w.points_seen, w.last);
   endfunction

   always @(posedge clock) begin
      report_word_type got;
      report_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.entry_valid    = rsp_chan.entry_valid;
         got.entry_id       = rsp_chan.entry_id;
         got.entry_distance = rsp_chan.entry_distance;
         got.box_lo[0]      = rsp_chan.min_x;
         got.box_lo[1]      = rsp_chan.min_y;
         got.box_lo[2]      = rsp_chan.min_z;
         got.box_hi[0]      = rsp_chan.max_x;
         got.box_hi[1]      = rsp_chan.max_y;
         got.box_hi[2]      = rsp_chan.max_z;
         got.points_seen    = rsp_chan.points_seen;
         got.last           = rsp_chan.last;
         if (pending_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("cycle %0d: report word with none expected: %s",
                        cycle_count, word_text(got));
         end else begin
            want = pending_words.pop_front();
            if (got.entry_valid !== want.entry_valid || got.entry_id !== want.entry_id ||
                got.entry_distance !== want.entry_distance ||
                got.box_lo !== want.box_lo || got.box_hi !== want.box_hi ||
                got.points_seen !== want.points_seen || got.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("cycle %0d: report word mismatch", cycle_count);
                  $display("  expected %s", word_text(want));
                  $display("  actual   %s", word_text(got));
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Run control
   // ---------------------------------------------------------------------------------------

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("nearest_k_points_with_bounds_unit_tb NOT OK");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_chan.valid   = 1'b0;
      req_chan.func    = FUNC_POINT;
      req_chan.pt_x    = '0;
      req_chan.pt_y    = '0;
      req_chan.pt_z    = '0;
      mismatch_count   = 0;
      items_sent       = 0;
      steady           = 1'b0;
      // Register values after reset.
      for (int a = 0; a < AXES; a++) query_at[a] = '0;
      use_depth  = 1'b0;
      keep_count = '0;
      restart_run();

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_run();
      test_extreme_distances();
      test_ties_and_full_list();
      test_count_changes();
      test_random_runs();

      wait_quiet();
      if (mismatch_count == 0 && pending_words.size() == 0)
         $display("nearest_k_points_with_bounds_unit_tb OK");
      else
         $display("nearest_k_points_with_bounds_unit_tb NOT OK");
      $finish;
   end

endmodule
